// ----- src/gtis_pkg.sv -----
// shared types, codes and byte-step functions of the gif transparent index scanner
`default_nettype none

package gtis_pkg;

   // parse phase codes
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_TABLE   = 3'd1;
   localparam logic [2:0] PH_BLOCK   = 3'd2;
   localparam logic [2:0] PH_SUBLEN  = 3'd3;
   localparam logic [2:0] PH_SUBDATA = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   // header layout and block markers
   localparam logic [3:0] SIG_LENGTH     = 4'd5;
   localparam logic [3:0] FLAGS_POSITION = 4'd10;
   localparam logic [3:0] HEADER_LAST    = 4'd15;
   localparam logic [7:0] EXT_INTRODUCER = 8'h21;
   localparam logic [7:0] GCE_LABEL      = 8'hf9;
   localparam logic [2:0] OFF_INTRO      = 3'd0;
   localparam logic [2:0] OFF_LABEL      = 3'd1;
   localparam logic [2:0] OFF_PACKED     = 3'd3;
   localparam logic [2:0] OFF_INDEX      = 3'd6;
   localparam logic [2:0] MARKS_ALL      = 3'b111;

   // bytes revisited after the header and after a block window
   localparam logic [2:0] REPLAY_NONE   = 3'd0;
   localparam logic [2:0] REPLAY_HEADER = 3'd3;
   localparam logic [2:0] REPLAY_BLOCK  = 3'd5;
   localparam int unsigned REPLAY_MAX   = 5;

   // parser state carried from byte to byte
   typedef struct packed {
      logic [2:0] phase;
      logic [3:0] hpos;
      logic       has_table;
      logic [2:0] table_size;
      logic [9:0] skip;
      logic [2:0] boff;
      logic [7:0] subrem;
      logic [2:0] marks;
      logic       done;
      logic       found;
      logic [7:0] index;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = parse_state_type'('0);

   // one result item plus its valid
   typedef struct packed {
      logic       valid;
      logic       found;
      logic [7:0] index;
   } gtis_result_type;

   // expected signature byte at a header position below five
   function automatic logic [7:0] sig_byte(input logic [3:0] pos);
      logic [7:0] sig;
      case (pos)
         4'd0:    sig = 8'h47;
         4'd1:    sig = 8'h49;
         4'd2:    sig = 8'h46;
         4'd3:    sig = 8'h38;
         4'd4:    sig = 8'h39;
         default: sig = 8'h00;
      endcase
      return sig;
   endfunction

   // number of earlier bytes to revisit after taking this byte
   function automatic logic [2:0] replay_len(input parse_state_type s);
      logic [2:0] n;
      n = REPLAY_NONE;
      if (s.phase == PH_HEADER && s.hpos == HEADER_LAST && !s.has_table) begin
         n = REPLAY_HEADER;
      end else if (s.phase == PH_BLOCK && s.boff >= OFF_INDEX && s.marks != MARKS_ALL) begin
         n = REPLAY_BLOCK;
      end
      return n;
   endfunction

   // one parse step over one byte
   function automatic parse_state_type consume(input parse_state_type s, input logic [7:0] b);
      parse_state_type n;
      logic [2:0]      mk;
      n  = s;
      mk = s.marks;
      case (s.phase)
         PH_HEADER: begin
            if (s.hpos < SIG_LENGTH && b != sig_byte(s.hpos)) begin
               n.done  = 1'b1;
               n.found = 1'b0;
               n.index = 8'h00;
               n.phase = PH_DONE;
            end else begin
               if (s.hpos == FLAGS_POSITION) begin
                  n.has_table  = b[7];
                  n.table_size = b[2:0];
               end
               if (s.hpos == HEADER_LAST) begin
                  if (s.has_table) begin
                     n.skip  = (10'd6 << s.table_size) - 10'd3;
                     n.phase = PH_TABLE;
                  end else begin
                     n.phase = PH_BLOCK;
                     n.boff  = 3'd0;
                     n.marks = 3'd0;
                  end
               end else begin
                  n.hpos = s.hpos + 4'd1;
               end
            end
         end
         PH_TABLE: begin
            n.skip = s.skip - 10'd1;
            if (n.skip == 10'd0) begin
               n.phase = PH_BLOCK;
               n.boff  = 3'd0;
               n.marks = 3'd0;
            end
         end
         PH_BLOCK: begin
            if (s.boff == OFF_INTRO && b != EXT_INTRODUCER) begin
               n.done  = 1'b1;
               n.found = 1'b0;
               n.index = 8'h00;
               n.phase = PH_DONE;
            end else begin
               if (s.boff == OFF_INTRO) mk[0] = 1'b1;
               if (s.boff == OFF_LABEL && b == GCE_LABEL) mk[1] = 1'b1;
               if (s.boff == OFF_PACKED && b[0]) mk[2] = 1'b1;
               n.marks = mk;
               if (s.boff >= OFF_INDEX) begin
                  if (mk == MARKS_ALL) begin
                     n.done  = 1'b1;
                     n.found = 1'b1;
                     n.index = b;
                     n.phase = PH_DONE;
                  end else begin
                     n.phase = PH_SUBLEN;
                  end
               end else begin
                  n.boff = s.boff + 3'd1;
               end
            end
         end
         PH_SUBLEN: begin
            if (b == 8'h00) begin
               n.phase = PH_BLOCK;
               n.boff  = 3'd0;
               n.marks = 3'd0;
            end else begin
               n.subrem = b;
               n.phase  = PH_SUBDATA;
            end
         end
         PH_SUBDATA: begin
            n.subrem = s.subrem - 8'd1;
            if (n.subrem == 8'h00) n.phase = PH_SUBLEN;
         end
         default: begin
            n = s;
         end
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- src/gif_transparent_index_scanner.sv -----
// top level of the gif transparent index scanner: input register, parser and result buffer
`default_nettype none

// Takes a GIF file one byte per transfer on req (req_tlast on the final byte)
// and returns one result per file on rsp: rsp_tuser is 1 when a GIF89 graphic
// control extension with its transparency flag set was found, and rsp_tdata
// carries its transparent colour index (0 when not found). The result appears
// as soon as the outcome is decided (bad signature, non-extension block,
// transparent index, or end of file); later bytes of the same file produce no
// result. One byte is accepted every cycle while the skid entry is free; a
// byte waits in the input register, then its result goes to the result
// register (or skid entry while stalled) and on to rsp. The per-byte critical
// path is the parser step chain: the new byte plus up to five revisited bytes
// (it again and up to four from history), one small compare-and-count step
// each. A two-entry result buffer keeps input flowing while a result waits.
module gif_transparent_index_scanner (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_file
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] transparent_index
   output logic            rsp_tuser    // [0] found
);
   import gtis_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            advance;
   gtis_result_type res;
   logic            out_valid_ff, out_valid_in;
   logic            out_found_ff, out_found_in;
   logic [7:0]      out_index_ff, out_index_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            skid_found_ff;
   logic [7:0]      skid_index_ff;
   logic            out_take;
   logic            skid_load;

   // input stage handshake
   assign advance     = in_valid_ff && !skid_valid_ff;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // parser
   gtis_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_byte_ff),
      .end_of_file (in_last_ff),
      .result      (res)
   );

   // result register with skid entry
   assign out_take = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_index_in  = out_index_ff;
      skid_valid_in = skid_valid_ff;
      skid_load     = 1'b0;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_found_in  = skid_found_ff;
            out_index_in  = skid_index_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res.valid;
            out_found_in = res.found;
            out_index_in = res.index;
         end
      end else if (res.valid) begin
         skid_valid_in = 1'b1;
         skid_load     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff <= out_found_in;
      out_index_ff <= out_index_in;
      if (skid_load) begin
         skid_found_ff <= res.found;
         skid_index_ff <= res.index;
      end
   end

   // result port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = out_index_ff;

endmodule

`default_nettype wire

// ----- src/gtis_parser.sv -----
// parser state, byte history and per-byte step chain of the gif transparent index scanner
`default_nettype none

module gtis_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     end_of_file,
   output gtis_pkg::gtis_result_type     result
);
   import gtis_pkg::*;

   parse_state_type state_ff, state_in;
   logic [7:0]      hist_ff [REPLAY_MAX-1];
   logic [7:0]      replay  [1:REPLAY_MAX];
   logic [2:0]      rep;
   parse_state_type s;

   // bytes to revisit, newest first
   always_comb begin
      replay[1] = data_byte;
      for (int j = 2; j <= REPLAY_MAX; j++) begin
         replay[j] = hist_ff[j-2];
      end
   end

   // take the new byte, then revisit recent bytes (the new byte among them) oldest first
   always_comb begin
      s   = state_ff;
      rep = REPLAY_NONE;
      if (!state_ff.done) begin
         rep = replay_len(state_ff);
         s   = consume(state_ff, data_byte);
         for (int j = REPLAY_MAX; j >= 1; j--) begin
            if (3'(j) <= rep && !s.done) begin
               s = consume(s, replay[j]);
            end
         end
      end
   end

   // result when the outcome is decided or the file ends undecided
   always_comb begin
      result.valid = advance && !state_ff.done && (s.done || end_of_file);
      result.found = s.done && s.found;
      result.index = s.done ? s.index : 8'h00;
      state_in     = end_of_file ? PARSE_RESET : s;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // recent byte history
   always_ff @(posedge clock) begin
      if (advance) begin
         hist_ff[0] <= data_byte;
         for (int j = 1; j < REPLAY_MAX - 1; j++) begin
            hist_ff[j] <= hist_ff[j-1];
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/gtis_checker.sv -----
// port-level checks of the gif transparent index scanner and their binding
`default_nettype none

module gtis_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // not found always carries index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("nonzero index without found");

   // with no result pending the input side is always open
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result buffer");

   // reset leaves no result offered
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind gif_transparent_index_scanner gtis_checker u_gtis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
